// ===== rtl/core/sync_length_checksum_deframer_macros.svh =====
// Assertion macros for the deframer RTL.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/slcd_pkg.sv =====
`default_nettype none
package slcd_pkg;

   typedef enum logic [1:0] {
      KIND_CODE = 2'd0,
      KIND_DATA = 2'd1,
      KIND_END  = 2'd2
   } item_kind_type;

   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_NULL     = 2'd2
   } frame_status_type;

   typedef enum logic [7:0] {
      PH_SYNC1   = 8'b0000_0001,
      PH_SYNC2   = 8'b0000_0010,
      PH_LENHI   = 8'b0000_0100,
      PH_LENLO   = 8'b0000_1000,
      PH_CODE    = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_SUMHI   = 8'b0100_0000,
      PH_SUMLO   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic             valid;
      item_kind_type    kind;
      logic [7:0]       data_value;
      frame_status_type status;
      logic             last;
   } result_type;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic        REG_SYNC_VALUE = 1'b0;

endpackage
`default_nettype wire

// ===== rtl/core/slcd_csr.sv =====
`default_nettype none
module slcd_csr
   import slcd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic      [7:0]                sync_value
);

   logic       reg_index;
   logic       write_en;
   logic [7:0] sync_value_ff;
   logic [7:0] sync_value_in;

   // Registers are word aligned, so the index is the address above the byte bits.
   assign reg_index  = csr_paddr[CSR_ADDR_WIDTH-1];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      sync_value_in = sync_value_ff;
      if (write_en && (reg_index == REG_SYNC_VALUE)) begin
         sync_value_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= 8'd0;
      end else begin
         sync_value_ff <= sync_value_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_SYNC_VALUE) begin
         csr_prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, sync_value_ff};
      end
   end

   assign sync_value = sync_value_ff;

endmodule
`default_nettype wire

// ===== rtl/core/slcd_parser.sv =====
`default_nettype none
module slcd_parser
   import slcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_accept,
   input  wire logic [7:0] rx_byte,
   input  wire logic [7:0] sync_value,
   output result_type      result
);

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic [15:0] sum_ff;
   logic [15:0] sum_in;
   logic [7:0]  sum_high_ff;
   logic [7:0]  sum_high_in;
   logic [15:0] count_dec;

   assign count_dec = count_ff - 16'd1;

   always_comb begin
      phase_in           = phase_ff;
      count_in           = count_ff;
      sum_in             = sum_ff;
      sum_high_in        = sum_high_ff;
      result.valid       = 1'b0;
      result.kind        = KIND_CODE;
      result.data_value  = 8'd0;
      result.status      = STATUS_VALID;
      result.last        = 1'b0;
      unique case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == sync_value) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            phase_in = (rx_byte == sync_value) ? PH_LENHI : PH_SYNC1;
         end
         PH_LENHI: begin
            count_in = {rx_byte, 8'd0};
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            count_in = {count_ff[15:8], rx_byte};
            phase_in = PH_CODE;
         end
         PH_CODE: begin
            result.valid = 1'b1;
            if (count_ff == 16'd0) begin
               // Null packet: the end result stands in for the data code.
               sum_in        = 16'd0;
               phase_in      = PH_SYNC1;
               result.kind   = KIND_END;
               result.status = STATUS_NULL;
               result.last   = 1'b1;
            end else begin
               sum_in            = {8'd0, rx_byte};
               count_in          = count_dec;
               phase_in          = (count_dec == 16'd0) ? PH_SUMHI : PH_PAYLOAD;
               result.data_value = rx_byte;
            end
         end
         PH_PAYLOAD: begin
            sum_in            = sum_ff + {8'd0, rx_byte};
            count_in          = count_dec;
            result.valid      = 1'b1;
            result.kind       = KIND_DATA;
            result.data_value = rx_byte;
            if (count_dec == 16'd0) begin
               phase_in = PH_SUMHI;
            end
         end
         PH_SUMHI: begin
            sum_high_in = rx_byte;
            phase_in    = PH_SUMLO;
         end
         PH_SUMLO: begin
            phase_in      = PH_SYNC1;
            result.valid  = 1'b1;
            result.kind   = KIND_END;
            result.last   = 1'b1;
            result.status = ({sum_high_ff, rx_byte} == sum_ff) ?
                            STATUS_VALID : STATUS_MISMATCH;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
      if (!byte_accept) begin
         phase_in     = phase_ff;
         count_in     = count_ff;
         sum_in       = sum_ff;
         sum_high_in  = sum_high_ff;
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         count_ff    <= 16'd0;
         sum_ff      <= 16'd0;
         sum_high_ff <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sum_high_ff <= sum_high_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/slcd_out_stage.sv =====
`default_nettype none
module slcd_out_stage
   import slcd_pkg::*;
`include "sync_length_checksum_deframer_macros.svh"
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type push_item,
   output logic            in_ready,
   output result_type      out_item,
   input  wire logic       out_ready
);

   result_type main_ff;
   result_type main_in;
   result_type skid_ff;
   result_type skid_in;
   logic       pop;

   assign pop      = main_ff.valid && out_ready;
   assign in_ready = !skid_ff.valid;

   always_comb begin
      main_in = main_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (push_item.valid) begin
         if (!main_ff.valid || pop) begin
            main_in = push_item;
         end else begin
            skid_in = push_item;
         end
      end else if (pop) begin
         main_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff.valid <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         main_ff.valid <= main_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
      main_ff.kind       <= main_in.kind;
      main_ff.data_value <= main_in.data_value;
      main_ff.status     <= main_in.status;
      main_ff.last       <= main_in.last;
      skid_ff.kind       <= skid_in.kind;
      skid_ff.data_value <= skid_in.data_value;
      skid_ff.status     <= skid_in.status;
      skid_ff.last       <= skid_in.last;
   end

   assign out_item = main_ff;

   `SLCD_ASSERT_SAME(a_skid_needs_main, clock, reset, skid_ff.valid, main_ff.valid, "skid full while output empty")
   `SLCD_ASSERT_SAME(a_no_push_when_full, clock, reset, push_item.valid, !skid_ff.valid, "result pushed into full stage")
   `SLCD_ASSERT_NEXT(a_skid_refills_main, clock, reset, skid_ff.valid && pop, main_ff.valid && !skid_ff.valid, "skid entry lost on drain")
   `SLCD_ASSERT_NEXT(a_stall_holds_end, clock, reset, main_ff.valid && !out_ready && main_ff.last, main_ff.valid && main_ff.last, "end result dropped while stalled")

endmodule
`default_nettype wire

// ===== rtl/core/sync_length_checksum_deframer.sv =====
// Sync-framed packet deframer with a 16-bit additive checksum. Received bytes enter on the
// req_ channel one per request; the block hunts for two bytes equal to the sync_value register,
// reads a big-endian 16-bit length (data code plus payload count), then the data code, the
// payload and a big-endian 16-bit checksum that must equal the wrapping 16-bit sum of the data
// code and payload bytes. It emits the data code, each payload byte, and an end request with
// tlast high and the frame status (valid, checksum mismatch, or null packet when the length is
// zero). Bytes that carry no result (sync, length, checksum high byte) are simply absorbed. The
// block takes one byte every cycle while req_tready is high: each byte is a single state update
// between the parser registers and a two-entry output register, and a result is registered into
// the main or skid entry and leaves on rsp_ from the main entry. req_tready falls only when both
// output entries hold results that the consumer has not taken. sync_value sits at byte address
// 0 of the configuration port and should only be written while no frame is in flight.
`default_nettype none
module sync_length_checksum_deframer
   import slcd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   // Received byte requests.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] rx_byte

   // Deframed result requests.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [15:0]               rsp_tdata,   // [7:0] data_value, [9:8] frame_status
   output logic      [1:0]                rsp_tuser,   // [1:0] item_kind
   output logic                           rsp_tlast,

   // Configuration port.
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic       byte_accept;
   logic [7:0] sync_value;
   result_type parsed;
   result_type out_item;

   // A byte is taken whenever the output stage has room for a possible result.
   assign byte_accept = req_tvalid && req_tready;

   slcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .sync_value  (sync_value)
   );

   slcd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .sync_value  (sync_value),
      .result      (parsed)
   );

   slcd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .push_item (parsed),
      .in_ready  (req_tready),
      .out_item  (out_item),
      .out_ready (rsp_tready)
   );

   // The status field packs above the data byte; the upper bits are zero filling.
   assign rsp_tvalid = out_item.valid;
   assign rsp_tdata  = {6'd0, out_item.status, out_item.data_value};
   assign rsp_tuser  = out_item.kind;
   assign rsp_tlast  = out_item.last;

endmodule
`default_nettype wire
